// File: rtl/llfc_pkg.sv
package llfc_pkg;

  localparam int LED_COUNT = 8;
  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int ACTIVE_W = 4;
  localparam int SVC_W = ($clog2(LED_COUNT + 1) > ACTIVE_W) ? $clog2(LED_COUNT + 1) : ACTIVE_W;
  localparam int LEVELS_W = 8;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  localparam logic [15:0] FLASH_FOREVER = 16'hFFFF;
  localparam logic [15:0] STEADY_ON = 16'hFFFF;
  localparam logic [15:0] COUNT_LIMIT = 16'd32766;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  led_id;
    logic        layer;
    logic [15:0] flash_count;
    logic [15:0] period;
  } in_word_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] led_levels;
    logic                ignored;
  } out_word_t;

  typedef struct packed {
    logic [15:0] cd;
    logic [15:0] rl;
    logic [15:0] tg;
  } layer_t;

  typedef struct packed {
    layer_t hi;
    layer_t lo;
  } entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        layer;
    logic [15:0] flash_count;
    logic [15:0] period;
  } cmd_t;

endpackage

// File: rtl/llfc_ram.sv
module llfc_ram
  import llfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata
);

  entry_t               mem [LED_COUNT];
  logic [LED_COUNT-1:0] valid_r;
  entry_t               rdata_r;
  logic                 rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

// File: rtl/llfc_update.sv
module llfc_update
  import llfc_pkg::*;
(
  input  cmd_t   cmd,
  input  entry_t cur,
  input  logic   drive,
  output entry_t nxt,
  output logic   drive_nxt
);

  typedef struct packed {
    layer_t l;
    logic   drive;
  } lay_res_t;

  function automatic lay_res_t expire(layer_t l, logic d);
    lay_res_t r;
    r.l = l;
    r.drive = ~d;
    if (l.tg != FLASH_FOREVER) begin
      r.l.tg = l.tg - 16'd1;
    end
    if (r.l.tg != '0) begin
      r.l.cd = l.rl;
    end else begin
      r.l = '0;
      r.drive = 1'b0;
    end
    return r;
  endfunction

  layer_t   hi;
  layer_t   lo;
  layer_t   sel;
  lay_res_t res;
  logic     d;

  always_comb begin
    nxt = cur;
    drive_nxt = drive;
    hi = cur.hi;
    lo = cur.lo;
    d = drive;
    sel = cmd.layer ? cur.lo : cur.hi;
    res = '0;
    unique case (cmd.op)
      REQ_TICK: begin
        if (hi.cd != '0) begin
          hi.cd = hi.cd - 16'd1;
          if (hi.cd == '0) begin
            res = expire(hi, d);
            hi = res.l;
            d = res.drive;
          end
        end else if (lo.cd != '0) begin
          if (lo.cd != STEADY_ON) begin
            lo.cd = lo.cd - 16'd1;
          end else begin
            d = 1'b1;
          end
          if (lo.cd == '0) begin
            res = expire(lo, d);
            lo = res.l;
            d = res.drive;
          end
        end
        nxt.hi = hi;
        nxt.lo = lo;
        drive_nxt = d;
      end
      REQ_START: begin
        if (cmd.flash_count == FLASH_FOREVER) begin
          sel.tg = FLASH_FOREVER;
        end else if (cmd.flash_count < COUNT_LIMIT) begin
          sel.tg = {cmd.flash_count[14:0], 1'b0};
        end
        sel.cd = 16'd1;
        sel.rl = cmd.period;
        if (cmd.layer) begin
          nxt.lo = sel;
        end else begin
          nxt.hi = sel;
        end
      end
      REQ_STOP: begin
        if (cmd.layer) begin
          nxt.lo = '0;
        end else begin
          nxt.hi = '0;
        end
        drive_nxt = 1'b0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: rtl/layered_led_flash_controller.sv
// Two-layer LED flash controller. Per-LED layer state lives in an on-chip memory with a registered
// read; each request reads an entry, updates it and writes it back in the cycle after the read,
// while the LED drive levels sit in flip-flops. A tick walks the serviced LEDs, from 0 up to
// but not including the smaller of the configured active count and eight, one per cycle. One
// word is handled at a time, and the next word is taken while a finished result still waits
// in the output register.
module layered_led_flash_controller
  import llfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ACTIVE_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [ACTIVE_W-1:0]  active_r;
  logic [SVC_W-1:0]     svc;
  logic [SVC_W-1:0]     active_ext;
  cmd_t                 cmd_r;
  logic                 ign_r;
  logic [IDX_W-1:0]     addr_r;
  logic [SVC_W-1:0]     left_r;
  logic                 p_vld_r;
  logic [IDX_W-1:0]     p_addr_r;
  logic [LED_COUNT-1:0] drive_r;
  logic                 out_valid_r;
  out_word_t            out_word_r;

  logic                 accept;
  logic                 bad_id;
  logic                 rd_fire;
  entry_t               rdata;
  entry_t               wdata;
  logic                 drive_new;
  logic [LEVELS_W-1:0]  levels;

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

  assign active_ext = SVC_W'(active_r);
  assign svc = (active_ext > SVC_W'(LED_COUNT)) ? SVC_W'(LED_COUNT) : active_ext;
  assign bad_id = (SVC_W'(in_word.led_id) >= svc);
  assign rd_fire = (state_r == S_RUN) && (left_r != '0);

  llfc_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (addr_r),
    .rdata (rdata),
    .we    (p_vld_r),
    .waddr (p_addr_r),
    .wdata (wdata)
  );

  llfc_update u_update (
    .cmd       (cmd_r),
    .cur       (rdata),
    .drive     (drive_r[p_addr_r]),
    .nxt       (wdata),
    .drive_nxt (drive_new)
  );

  always_comb begin
    levels = '0;
    for (int i = 0; i < LEVELS_W && i < LED_COUNT; i++) begin
      levels[i] = drive_r[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (left_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACTIVE_RESET;
      left_r      <= '0;
      p_vld_r     <= 1'b0;
      drive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
      p_vld_r <= rd_fire;
      if (accept) begin
        if (in_word.req_type == REQ_TICK) begin
          left_r <= svc;
        end else if ((in_word.req_type == REQ_START || in_word.req_type == REQ_STOP)
                     && !bad_id) begin
          left_r <= SVC_W'(1);
        end else begin
          left_r <= '0;
        end
      end else if (rd_fire) begin
        left_r <= left_r - SVC_W'(1);
      end
      if (p_vld_r) begin
        drive_r[p_addr_r] <= drive_new;
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.op          <= in_word.req_type;
      cmd_r.layer       <= in_word.layer;
      cmd_r.flash_count <= in_word.flash_count;
      cmd_r.period      <= in_word.period;
      ign_r  <= (in_word.req_type == REQ_START || in_word.req_type == REQ_STOP) && bad_id;
      addr_r <= (in_word.req_type == REQ_TICK) ? '0 : IDX_W'(in_word.led_id);
    end else if (rd_fire) begin
      addr_r <= addr_r + IDX_W'(1);
    end
    if (rd_fire) begin
      p_addr_r <= addr_r;
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_word_r.led_levels <= levels;
      out_word_r.ignored    <= ign_r;
    end
  end

endmodule
